// ===== rtl/core/dexp_pkg.sv =====
// shared types, constants and helpers for the double exp pipeline
`default_nettype none

package dexp_pkg;

  localparam int FmaLat  = 11;
  localparam int RintLat = 2;
  localparam int DataLat = 9 * FmaLat + RintLat;
  localparam int ExpW    = 14;

  typedef logic [63:0] dbl_t;
  typedef logic signed [ExpW-1:0] exp_t;

  localparam dbl_t ZeroBits  = 64'h0000_0000_0000_0000;
  localparam dbl_t OneBits   = 64'h3FF0_0000_0000_0000;
  localparam dbl_t InfBits   = 64'h7FF0_0000_0000_0000;
  localparam dbl_t Log2eBits = $realtobits(1.44269504088896340736);
  localparam dbl_t XmaxBits  = $realtobits(708.39);
  localparam dbl_t Ln2HiBits = $realtobits(0.693145751953125);
  localparam dbl_t Ln2LoBits = $realtobits(1.42860682030941723212e-6);

  localparam dbl_t TaylorBits [12] = '{
    $realtobits(1.0 / 2.0),        $realtobits(1.0 / 6.0),
    $realtobits(1.0 / 24.0),       $realtobits(1.0 / 120.0),
    $realtobits(1.0 / 720.0),      $realtobits(1.0 / 5040.0),
    $realtobits(1.0 / 40320.0),    $realtobits(1.0 / 362880.0),
    $realtobits(1.0 / 3628800.0),  $realtobits(1.0 / 39916800.0),
    $realtobits(1.0 / 479001600.0), $realtobits(1.0 / 6227020800.0)
  };

  // index of the highest set bit, zero when none
  function automatic logic [6:0] top_bit(input logic [127:0] v);
    logic [6:0] t;
    t = '0;
    for (int i = 0; i < 128; i++) begin
      if (v[i]) begin
        t = 7'(i);
      end
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dexp_delay.sv =====
// fixed-length register delay line
`default_nettype none

module dexp_delay import dexp_pkg::*; #(
  parameter int Width = 64,
  parameter int Depth = FmaLat
) (
  input  logic             clk_i,
  input  logic [Width-1:0] d_i,
  output logic [Width-1:0] q_o
);

  logic [Width-1:0] pipe_q [Depth];

  always_ff @(posedge clk_i) begin
    pipe_q[0] <= d_i;
    for (int i = 1; i < Depth; i++) begin
      pipe_q[i] <= pipe_q[i-1];
    end
  end

  assign q_o = pipe_q[Depth-1];

endmodule

`default_nettype wire

// ===== rtl/core/dexp_fma.sv =====
// pipelined binary64 fused multiply-add, one rounding, nearest even
`default_nettype none

module dexp_fma import dexp_pkg::*; (
  input  logic clk_i,
  input  dbl_t a_i,
  input  dbl_t b_i,
  input  dbl_t c_i,
  output dbl_t res_o
);

  // unpack
  logic [10:0] xa, xb, xc;
  logic [52:0] ma, mb, mc;
  exp_t        ea, eb, ec;

  assign xa = a_i[62:52];
  assign xb = b_i[62:52];
  assign xc = c_i[62:52];
  assign ma = {|xa, a_i[51:0]};
  assign mb = {|xb, b_i[51:0]};
  assign mc = {|xc, c_i[51:0]};
  assign ea = (|xa) ? ($signed({3'b000, xa}) - 14'sd1075) : -14'sd1074;
  assign eb = (|xb) ? ($signed({3'b000, xb}) - 14'sd1075) : -14'sd1074;
  assign ec = (|xc) ? ($signed({3'b000, xc}) - 14'sd1075) : -14'sd1074;

  logic [53:0]  pp11_q;
  logic [52:0]  pp10_q, pp01_q;
  logic [51:0]  pp00_q;
  exp_t         eab1_q, ec1_q;
  logic [52:0]  mc1_q;
  logic         sp1_q, sc1_q, zab1_q;
  dbl_t         c1_q;

  logic [105:0] p_d;
  logic [6:0]   tc_d;
  logic [105:0] p2_q;
  logic [6:0]   tc2_q;
  exp_t         eab2_q, ec2_q;
  logic [52:0]  mc2_q;
  logic         sp2_q, sc2_q, zab2_q;
  dbl_t         c2_q;

  logic [6:0]   tp_d;
  logic [127:0] cw_d;
  exp_t         ecn_d;
  logic [105:0] p3_q;
  logic [6:0]   tp3_q;
  logic [127:0] cw3_q;
  exp_t         eab3_q, ec3_q;
  logic         sp3_q, sc3_q, zab3_q, mcz3_q;
  dbl_t         c3_q;

  logic [127:0] pn_d;
  exp_t         ep_d;
  logic [127:0] pn4_q, cw4_q;
  exp_t         ep4_q, ec4_q;
  logic         sp4_q, sc4_q, zab4_q, mcz4_q;
  dbl_t         c4_q;

  logic         ge;
  exp_t         dd;
  logic [127:0] big5_q, small5_q;
  logic [7:0]   d5_q;
  exp_t         e5_q;
  logic         sl5_q, sub5_q, sp5_q, sc5_q, zab5_q, mcz5_q;
  dbl_t         c5_q;

  logic [127:0] sm_d;
  logic [127:0] big6_q, sm6_q;
  exp_t         e6_q;
  logic         sl6_q, sub6_q, sp6_q, sc6_q, zab6_q, mcz6_q;
  dbl_t         c6_q;

  logic [127:0] sum_d;
  logic [127:0] sum7_q;
  exp_t         e7_q;
  logic         sl7_q, spec7_q;
  dbl_t         sv7_q;

  logic [127:0] sum8_q;
  logic [6:0]   t8_q;
  exp_t         e8_q;
  logic         sl8_q, spec8_q;
  dbl_t         sv8_q;

  exp_t         be_d, s_d;
  logic [127:0] sum9_q;
  exp_t         be9_q, s9_q;
  logic         sl9_q, spec9_q;
  dbl_t         sv9_q;

  logic [6:0]   ls, rs;
  exp_t         negs;
  logic [127:0] lsh, rsh;
  logic [53:0]  q_d;
  logic         half, below;
  logic [53:0]  q10_q;
  logic         inc10_q;
  exp_t         be10_q;
  logic         sl10_q, spec10_q;
  dbl_t         sv10_q;

  logic [53:0]  q2, qn;
  exp_t         be2;
  dbl_t         res_d;
  dbl_t         res_q;

  // product sum and addend normalization
  always_comb begin
    p_d = {pp11_q, 52'b0} + {27'b0, pp10_q, 26'b0} + {27'b0, pp01_q, 26'b0}
        + {54'b0, pp00_q};
    tc_d  = top_bit({75'b0, mc1_q});
    tp_d  = top_bit({22'b0, p2_q});
    cw_d  = {75'b0, mc2_q} << (7'd125 - tc2_q);
    ecn_d = ec2_q - $signed({7'b0, 7'(7'd125 - tc2_q)});
    pn_d  = {22'b0, p3_q} << (7'd125 - tp3_q);
    ep_d  = eab3_q - $signed({7'b0, 7'(7'd125 - tp3_q)});
  end

  // operand swap, alignment and add or subtract
  always_comb begin
    ge = mcz4_q || (ep4_q > ec4_q) || ((ep4_q == ec4_q) && (pn4_q >= cw4_q));
    dd = ge ? (ep4_q - ec4_q) : (ec4_q - ep4_q);
    if (d5_q == 8'd0) begin
      sm_d = small5_q;
    end else if (d5_q[7]) begin
      sm_d = {127'b0, |small5_q};
    end else begin
      sm_d = (small5_q >> d5_q[6:0])
           | {127'b0, |(small5_q & ((128'd1 << d5_q[6:0]) - 128'd1))};
    end
    sum_d = sub6_q ? (big6_q - sm6_q) : (big6_q + sm6_q);
  end

  // rounding position and final pack
  always_comb begin
    be_d = $signed({7'b0, t8_q}) + e8_q + 14'sd1023;
    s_d  = (be_d >= 14'sd1) ? ($signed({7'b0, t8_q}) - 14'sd52) : (-14'sd1074 - e8_q);

    negs  = -s9_q;
    ls    = negs[6:0];
    rs    = s9_q[6:0];
    lsh   = sum9_q << ls;
    rsh   = sum9_q >> rs;
    half  = 1'b0;
    below = 1'b0;
    if (s9_q <= 14'sd0) begin
      q_d = lsh[53:0];
    end else if (s9_q >= 14'sd128) begin
      q_d = '0;
    end else begin
      q_d   = rsh[53:0];
      half  = sum9_q[7'(rs - 7'd1)];
      below = |(sum9_q & ((128'd1 << (rs - 7'd1)) - 128'd1));
    end

    q2  = q10_q + 54'(inc10_q);
    be2 = q2[53] ? (be10_q + 14'sd1) : be10_q;
    qn  = q2[53] ? (q2 >> 1) : q2;
    if (spec10_q) begin
      res_d = sv10_q;
    end else if (be10_q >= 14'sd2047) begin
      res_d = {sl10_q, InfBits[62:0]};
    end else if (be10_q >= 14'sd1) begin
      if (be2 >= 14'sd2047) begin
        res_d = {sl10_q, InfBits[62:0]};
      end else begin
        res_d = {sl10_q, be2[10:0], qn[51:0]};
      end
    end else begin
      res_d = {sl10_q, 9'b0, q2};
    end
  end

  always_ff @(posedge clk_i) begin
    pp11_q <= 54'(ma[52:26]) * 54'(mb[52:26]);
    pp10_q <= 53'(ma[52:26]) * 53'(mb[25:0]);
    pp01_q <= 53'(ma[25:0]) * 53'(mb[52:26]);
    pp00_q <= 52'(ma[25:0]) * 52'(mb[25:0]);
    eab1_q <= ea + eb;
    ec1_q  <= ec;
    mc1_q  <= mc;
    sp1_q  <= a_i[63] ^ b_i[63];
    sc1_q  <= c_i[63];
    zab1_q <= (ma == '0) || (mb == '0);
    c1_q   <= c_i;

    p2_q   <= p_d;
    tc2_q  <= tc_d;
    eab2_q <= eab1_q;
    ec2_q  <= ec1_q;
    mc2_q  <= mc1_q;
    sp2_q  <= sp1_q;
    sc2_q  <= sc1_q;
    zab2_q <= zab1_q;
    c2_q   <= c1_q;

    p3_q   <= p2_q;
    tp3_q  <= tp_d;
    cw3_q  <= cw_d;
    ec3_q  <= ecn_d;
    eab3_q <= eab2_q;
    sp3_q  <= sp2_q;
    sc3_q  <= sc2_q;
    zab3_q <= zab2_q;
    mcz3_q <= (mc2_q == '0);
    c3_q   <= c2_q;

    pn4_q  <= pn_d;
    ep4_q  <= ep_d;
    cw4_q  <= cw3_q;
    ec4_q  <= ec3_q;
    sp4_q  <= sp3_q;
    sc4_q  <= sc3_q;
    zab4_q <= zab3_q;
    mcz4_q <= mcz3_q;
    c4_q   <= c3_q;

    big5_q   <= ge ? pn4_q : cw4_q;
    small5_q <= ge ? cw4_q : pn4_q;
    sl5_q    <= ge ? sp4_q : sc4_q;
    e5_q     <= ge ? ep4_q : ec4_q;
    d5_q     <= ((dd > 14'sd127) || (dd < 14'sd0)) ? 8'd128 : dd[7:0];
    sub5_q   <= sp4_q ^ sc4_q;
    sp5_q    <= sp4_q;
    sc5_q    <= sc4_q;
    zab5_q   <= zab4_q;
    mcz5_q   <= mcz4_q;
    c5_q     <= c4_q;

    big6_q <= big5_q;
    sm6_q  <= sm_d;
    e6_q   <= e5_q;
    sl6_q  <= sl5_q;
    sub6_q <= sub5_q;
    sp6_q  <= sp5_q;
    sc6_q  <= sc5_q;
    zab6_q <= zab5_q;
    mcz6_q <= mcz5_q;
    c6_q   <= c5_q;

    sum7_q  <= sum_d;
    e7_q    <= e6_q;
    sl7_q   <= sl6_q;
    spec7_q <= zab6_q || (sum_d == '0);
    sv7_q   <= zab6_q ? (mcz6_q ? {sp6_q & sc6_q, 63'b0} : c6_q) : ZeroBits;

    sum8_q  <= sum7_q;
    t8_q    <= top_bit(sum7_q);
    e8_q    <= e7_q;
    sl8_q   <= sl7_q;
    spec8_q <= spec7_q;
    sv8_q   <= sv7_q;

    sum9_q  <= sum8_q;
    be9_q   <= be_d;
    s9_q    <= s_d;
    sl9_q   <= sl8_q;
    spec9_q <= spec8_q;
    sv9_q   <= sv8_q;

    q10_q    <= q_d;
    inc10_q  <= half & (below | q_d[0]);
    be10_q   <= be9_q;
    sl10_q   <= sl9_q;
    spec10_q <= spec9_q;
    sv10_q   <= sv9_q;

    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/dexp_rint.sv =====
// round to nearest even integer, builds -r and the 2^r scale
`default_nettype none

module dexp_rint import dexp_pkg::*; (
  input  logic clk_i,
  input  dbl_t v_i,
  output dbl_t neg_r_o,
  output dbl_t scale_o
);

  logic [10:0] xv;
  logic [52:0] m;
  logic [5:0]  sh;
  logic [52:0] q;
  logic        half, below;
  logic [10:0] mag_d;
  logic [10:0] mag_q;
  logic        neg_q;
  logic [6:0]  tm;
  logic [52:0] fw;
  dbl_t        nr_d;
  logic [10:0] se_d;
  dbl_t        nr_q, scl_q;

  always_comb begin
    xv    = v_i[62:52];
    m     = {|xv, v_i[51:0]};
    sh    = 6'(11'd1075 - xv);
    q     = m >> sh;
    half  = m[6'(sh - 6'd1)];
    below = |(m & ((53'd1 << (sh - 6'd1)) - 53'd1));
    if (xv < 11'd1022) begin
      mag_d = '0;
    end else if (xv >= 11'd1075) begin
      mag_d = m[10:0];
    end else begin
      mag_d = q[10:0] + 11'(half & (below | q[0]));
    end
  end

  always_comb begin
    tm = top_bit({117'b0, mag_q});
    fw = {42'b0, mag_q} << (7'd52 - tm);
    if (mag_q == '0) begin
      nr_d = {1'b1, 63'b0};
    end else begin
      nr_d = {~neg_q, 11'(11'd1023 + 11'(tm)), fw[51:0]};
    end
    se_d = neg_q ? (11'd1023 - mag_q) : (11'd1023 + mag_q);
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= v_i[63];
    nr_q  <= nr_d;
    scl_q <= {1'b0, se_d, 52'b0};
  end

  assign neg_r_o = nr_q;
  assign scale_o = scl_q;

endmodule

`default_nettype wire

// ===== rtl/core/double_exp_function.sv =====
// double precision exp top level: range reduction, taylor tree, scaling
//
//   channel   signals                          direction
//   request   start, operand_bits_i            in
//             busy                             out
//   result    done_o, result_bits_o            out
//
// one request per cycle, busy stays low; every request returns one result
// each result passes through 9 dependent fma passes, the rounding stage and an output register
// reset clears the valid chain and the result strobe only
// the receiver takes every result, nothing in the pipeline ever waits
`default_nettype none

module double_exp_function import dexp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] operand_bits_i,
  output logic        done_o,
  output logic [63:0] result_bits_o
);

  logic [DataLat-1:0] vld_q;
  dbl_t v, nr, scl, x0d, xc, nrd, x, xd, x2, x4, x8;
  dbl_t t [6];
  dbl_t t13d, u3, u7, u11, v7, v13, poly, z1, scld, res, opd;
  dbl_t out_d, out_q;
  logic done_q;
  logic in_range;

  assign busy = 1'b0;

  dexp_fma u_mul_l2e (.clk_i, .a_i(operand_bits_i), .b_i(Log2eBits), .c_i(ZeroBits),
                      .res_o(v));
  dexp_rint u_rint (.clk_i, .v_i(v), .neg_r_o(nr), .scale_o(scl));

  dexp_delay #(.Width(64), .Depth(FmaLat + RintLat)) u_dly_x0 (
    .clk_i, .d_i(operand_bits_i), .q_o(x0d));
  dexp_fma u_red_hi (.clk_i, .a_i(nr), .b_i(Ln2HiBits), .c_i(x0d), .res_o(xc));
  dexp_delay #(.Width(64), .Depth(FmaLat)) u_dly_nr (.clk_i, .d_i(nr), .q_o(nrd));
  dexp_fma u_red_lo (.clk_i, .a_i(nrd), .b_i(Ln2LoBits), .c_i(xc), .res_o(x));

  // first tree level
  dexp_fma u_sq2 (.clk_i, .a_i(x), .b_i(x), .c_i(ZeroBits), .res_o(x2));
  for (genvar k = 0; k < 6; k++) begin : g_lin
    dexp_fma u_lin (.clk_i, .a_i(TaylorBits[2*k+1]), .b_i(x), .c_i(TaylorBits[2*k]),
                    .res_o(t[k]));
  end
  dexp_delay #(.Width(64), .Depth(FmaLat)) u_dly_x (.clk_i, .d_i(x), .q_o(xd));
  dexp_delay #(.Width(64), .Depth(FmaLat)) u_dly_t13 (.clk_i, .d_i(t[5]), .q_o(t13d));

  // second tree level
  dexp_fma u_sq4 (.clk_i, .a_i(x2), .b_i(x2), .c_i(ZeroBits), .res_o(x4));
  dexp_fma u_u3 (.clk_i, .a_i(t[0]), .b_i(x2), .c_i(xd), .res_o(u3));
  dexp_fma u_u7 (.clk_i, .a_i(t[2]), .b_i(x2), .c_i(t[1]), .res_o(u7));
  dexp_fma u_u11 (.clk_i, .a_i(t[4]), .b_i(x2), .c_i(t[3]), .res_o(u11));

  // third tree level
  dexp_fma u_sq8 (.clk_i, .a_i(x4), .b_i(x4), .c_i(ZeroBits), .res_o(x8));
  dexp_fma u_v7 (.clk_i, .a_i(u7), .b_i(x4), .c_i(u3), .res_o(v7));
  dexp_fma u_v13 (.clk_i, .a_i(t13d), .b_i(x4), .c_i(u11), .res_o(v13));

  dexp_fma u_poly (.clk_i, .a_i(v13), .b_i(x8), .c_i(v7), .res_o(poly));
  dexp_fma u_inc (.clk_i, .a_i(poly), .b_i(OneBits), .c_i(OneBits), .res_o(z1));

  dexp_delay #(.Width(64), .Depth(7 * FmaLat)) u_dly_scl (.clk_i, .d_i(scl), .q_o(scld));
  dexp_fma u_scale (.clk_i, .a_i(z1), .b_i(scld), .c_i(ZeroBits), .res_o(res));

  dexp_delay #(.Width(64), .Depth(DataLat)) u_dly_op (
    .clk_i, .d_i(operand_bits_i), .q_o(opd));

  // special operands
  always_comb begin
    in_range = (opd[62:0] < XmaxBits[62:0]) && (opd[62:52] != 11'h7FF);
    if (in_range) begin
      out_d = res;
    end else if (opd[62:0] > InfBits[62:0]) begin
      out_d = opd;
    end else if (opd[63]) begin
      out_d = ZeroBits;
    end else begin
      out_d = InfBits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[DataLat-2:0], start};
      done_q <= vld_q[DataLat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o        = done_q;
  assign result_bits_o = out_q;

endmodule

`default_nettype wire
